/* hdl/udp_hdr_pkg.sv */
`timescale 1ns / 1ps

package udp_hdr_pkg;

    localparam logic [15:0] MAX_PAYLOAD = 16'd1472;
    localparam logic [4:0]  HDR_LAST    = 5'd27;

    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  PROTO_UDP   = 8'h11;

    localparam logic [2:0]  CFG_SRC_ADDR = 3'd0;
    localparam logic [2:0]  CFG_SRC_PORT = 3'd1;
    localparam logic [2:0]  CFG_DST_ADDR = 3'd2;
    localparam logic [2:0]  CFG_DST_PORT = 3'd3;
    localparam logic [2:0]  CFG_TTL      = 3'd4;

    localparam logic [2:0]  OP_NOP     = 3'd0;
    localparam logic [2:0]  OP_ADD_UDP = 3'd1;
    localparam logic [2:0]  OP_ADD_IP  = 3'd2;
    localparam logic [2:0]  OP_EMIT    = 3'd3;
    localparam logic [2:0]  OP_CLEAR   = 3'd4;

    localparam logic [3:0]  W_ZERO    = 4'd0;
    localparam logic [3:0]  W_ODDPAD  = 4'd1;
    localparam logic [3:0]  W_4500    = 4'd2;
    localparam logic [3:0]  W_IPTOL   = 4'd3;
    localparam logic [3:0]  W_TTLPROT = 4'd4;
    localparam logic [3:0]  W_SAHI    = 4'd5;
    localparam logic [3:0]  W_SALO    = 4'd6;
    localparam logic [3:0]  W_DAHI    = 4'd7;
    localparam logic [3:0]  W_DALO    = 4'd8;
    localparam logic [3:0]  W_0011    = 4'd9;
    localparam logic [3:0]  W_UDPLEN  = 4'd10;
    localparam logic [3:0]  W_SPORT   = 4'd11;
    localparam logic [3:0]  W_DPORT   = 4'd12;

    localparam logic [1:0]  COND_NONE      = 2'd0;
    localparam logic [1:0]  COND_ALWAYS    = 2'd1;
    localparam logic [1:0]  COND_NO_START  = 2'd2;
    localparam logic [1:0]  COND_EMIT_LOOP = 2'd3;

    localparam logic [4:0]  PC_IDLE = 5'd0;
    localparam logic [4:0]  PC_EMIT = 5'd18;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [7:0]  ttl;
    } cfg_t;

    typedef struct packed {
        logic       in_ready;
        logic [2:0] op;
        logic [3:0] wsel;
        logic [1:0] cond;
        logic [4:0] target;
    } ctl_t;

    typedef struct packed {
        logic start;
        logic emit_done;
    } status_t;

    function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
        logic [17:0] t;
        t = {1'b0, s} + {2'b00, w};
        return {1'b0, t[15:0]} + {15'd0, t[17:16]};
    endfunction

    function automatic logic [15:0] oc_final(input logic [16:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + {16'd0, s[16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return ~f2[15:0];
    endfunction

    function automatic ctl_t rom(input logic [4:0] pc);
        ctl_t c;
        c = '{in_ready: 1'b0, op: OP_NOP, wsel: W_ZERO, cond: COND_NONE, target: PC_IDLE};
        case (pc)
            5'd0:  begin
                c.in_ready = 1'b1;
                c.cond     = COND_NO_START;
                c.target   = PC_IDLE;
            end
            5'd1:  begin c.op = OP_ADD_UDP; c.wsel = W_ODDPAD;  end
            5'd2:  begin c.op = OP_ADD_UDP; c.wsel = W_SAHI;    end
            5'd3:  begin c.op = OP_ADD_UDP; c.wsel = W_SALO;    end
            5'd4:  begin c.op = OP_ADD_UDP; c.wsel = W_DAHI;    end
            5'd5:  begin c.op = OP_ADD_UDP; c.wsel = W_DALO;    end
            5'd6:  begin c.op = OP_ADD_UDP; c.wsel = W_0011;    end
            5'd7:  begin c.op = OP_ADD_UDP; c.wsel = W_UDPLEN;  end
            5'd8:  begin c.op = OP_ADD_UDP; c.wsel = W_SPORT;   end
            5'd9:  begin c.op = OP_ADD_UDP; c.wsel = W_DPORT;   end
            5'd10: begin c.op = OP_ADD_UDP; c.wsel = W_UDPLEN;  end
            5'd11: begin c.op = OP_ADD_IP;  c.wsel = W_4500;    end
            5'd12: begin c.op = OP_ADD_IP;  c.wsel = W_IPTOL;   end
            5'd13: begin c.op = OP_ADD_IP;  c.wsel = W_TTLPROT; end
            5'd14: begin c.op = OP_ADD_IP;  c.wsel = W_SAHI;    end
            5'd15: begin c.op = OP_ADD_IP;  c.wsel = W_SALO;    end
            5'd16: begin c.op = OP_ADD_IP;  c.wsel = W_DAHI;    end
            5'd17: begin c.op = OP_ADD_IP;  c.wsel = W_DALO;    end
            5'd18: begin
                c.op     = OP_EMIT;
                c.cond   = COND_EMIT_LOOP;
                c.target = PC_EMIT;
            end
            5'd19: begin
                c.op     = OP_CLEAR;
                c.cond   = COND_ALWAYS;
                c.target = PC_IDLE;
            end
            default: begin
                c.cond   = COND_ALWAYS;
                c.target = PC_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

/* hdl/udp_hdr_seq.sv */
`timescale 1ns / 1ps

module udp_hdr_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  udp_hdr_pkg::status_t status,
    output udp_hdr_pkg::ctl_t    ctl
);

    logic [4:0] pc_reg;
    logic [4:0] pc_next;
    logic       jump;

    assign ctl = udp_hdr_pkg::rom(pc_reg);

    always_comb begin
        unique case (ctl.cond)
            udp_hdr_pkg::COND_NONE:      jump = 1'b0;
            udp_hdr_pkg::COND_ALWAYS:    jump = 1'b1;
            udp_hdr_pkg::COND_NO_START:  jump = !status.start;
            udp_hdr_pkg::COND_EMIT_LOOP: jump = !status.emit_done;
            default:                     jump = 1'b1;
        endcase
        pc_next = jump ? ctl.target : pc_reg + 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= udp_hdr_pkg::PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hdl/udp_hdr_dp.sv */
`timescale 1ns / 1ps

module udp_hdr_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  udp_hdr_pkg::cfg_t    cfg,
    input  udp_hdr_pkg::ctl_t    ctl,
    input  logic                 in_accept,
    input  logic [7:0]           in_byte,
    output logic                 emit_done,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_header_byte,
    output logic [4:0]           m_header_offset,
    output logic                 m_header_last,
    output logic                 m_length_overflow
);

    logic [15:0] byte_count_reg;
    logic [16:0] running_sum_reg;
    logic [7:0]  held_high_reg;
    logic        odd_pending_reg;
    logic        overflow_reg;
    logic [16:0] ip_sum_reg;
    logic [4:0]  emit_cnt_reg;

    logic        m_valid_reg;
    logic [7:0]  m_byte_reg;
    logic [4:0]  m_offset_reg;
    logic        m_last_reg;
    logic        m_ovf_reg;

    logic [15:0] iptol;
    logic [15:0] udplen;
    logic [15:0] ipck;
    logic [15:0] udpck_raw;
    logic [15:0] udpck;
    logic [15:0] word;
    logic [16:0] acc_in;
    logic [16:0] acc_sum;
    logic        slot_free;
    logic        do_emit;
    logic [7:0]  hdr_byte;

    assign iptol     = byte_count_reg + 16'd28;
    assign udplen    = byte_count_reg + 16'd8;
    assign ipck      = udp_hdr_pkg::oc_final(ip_sum_reg);
    assign udpck_raw = udp_hdr_pkg::oc_final(running_sum_reg);
    assign udpck     = (udpck_raw == 16'd0) ? 16'hffff : udpck_raw;
    assign slot_free = !m_valid_reg || m_ready;
    assign do_emit   = (ctl.op == udp_hdr_pkg::OP_EMIT) && slot_free;
    assign emit_done = slot_free && (emit_cnt_reg == udp_hdr_pkg::HDR_LAST);

    always_comb begin
        unique case (ctl.wsel)
            udp_hdr_pkg::W_ZERO:    word = 16'h0000;
            udp_hdr_pkg::W_ODDPAD:  word = odd_pending_reg ? {held_high_reg, 8'h00} : 16'h0000;
            udp_hdr_pkg::W_4500:    word = {udp_hdr_pkg::VER_IHL, 8'h00};
            udp_hdr_pkg::W_IPTOL:   word = iptol;
            udp_hdr_pkg::W_TTLPROT: word = {cfg.ttl, udp_hdr_pkg::PROTO_UDP};
            udp_hdr_pkg::W_SAHI:    word = cfg.src_addr[31:16];
            udp_hdr_pkg::W_SALO:    word = cfg.src_addr[15:0];
            udp_hdr_pkg::W_DAHI:    word = cfg.dst_addr[31:16];
            udp_hdr_pkg::W_DALO:    word = cfg.dst_addr[15:0];
            udp_hdr_pkg::W_0011:    word = {8'h00, udp_hdr_pkg::PROTO_UDP};
            udp_hdr_pkg::W_UDPLEN:  word = udplen;
            udp_hdr_pkg::W_SPORT:   word = cfg.src_port;
            udp_hdr_pkg::W_DPORT:   word = cfg.dst_port;
            default:                word = 16'h0000;
        endcase
        acc_in  = (ctl.op == udp_hdr_pkg::OP_ADD_IP) ? ip_sum_reg : running_sum_reg;
        acc_sum = udp_hdr_pkg::oc_add(acc_in, word);
    end

    always_comb begin
        case (emit_cnt_reg)
            5'd0:    hdr_byte = udp_hdr_pkg::VER_IHL;
            5'd2:    hdr_byte = iptol[15:8];
            5'd3:    hdr_byte = iptol[7:0];
            5'd8:    hdr_byte = cfg.ttl;
            5'd9:    hdr_byte = udp_hdr_pkg::PROTO_UDP;
            5'd10:   hdr_byte = ipck[15:8];
            5'd11:   hdr_byte = ipck[7:0];
            5'd12:   hdr_byte = cfg.src_addr[31:24];
            5'd13:   hdr_byte = cfg.src_addr[23:16];
            5'd14:   hdr_byte = cfg.src_addr[15:8];
            5'd15:   hdr_byte = cfg.src_addr[7:0];
            5'd16:   hdr_byte = cfg.dst_addr[31:24];
            5'd17:   hdr_byte = cfg.dst_addr[23:16];
            5'd18:   hdr_byte = cfg.dst_addr[15:8];
            5'd19:   hdr_byte = cfg.dst_addr[7:0];
            5'd20:   hdr_byte = cfg.src_port[15:8];
            5'd21:   hdr_byte = cfg.src_port[7:0];
            5'd22:   hdr_byte = cfg.dst_port[15:8];
            5'd23:   hdr_byte = cfg.dst_port[7:0];
            5'd24:   hdr_byte = udplen[15:8];
            5'd25:   hdr_byte = udplen[7:0];
            5'd26:   hdr_byte = udpck[15:8];
            5'd27:   hdr_byte = udpck[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= 16'd0;
            running_sum_reg <= 17'd0;
            held_high_reg   <= 8'd0;
            odd_pending_reg <= 1'b0;
            overflow_reg    <= 1'b0;
            ip_sum_reg      <= 17'd0;
            emit_cnt_reg    <= 5'd0;
        end else begin
            if (in_accept) begin
                if (byte_count_reg >= udp_hdr_pkg::MAX_PAYLOAD) begin
                    overflow_reg <= 1'b1;
                end else begin
                    byte_count_reg <= byte_count_reg + 16'd1;
                    if (odd_pending_reg) begin
                        running_sum_reg <= udp_hdr_pkg::oc_add(running_sum_reg,
                                                               {held_high_reg, in_byte});
                        odd_pending_reg <= 1'b0;
                    end else begin
                        held_high_reg   <= in_byte;
                        odd_pending_reg <= 1'b1;
                    end
                end
            end
            case (ctl.op)
                udp_hdr_pkg::OP_ADD_UDP: running_sum_reg <= acc_sum;
                udp_hdr_pkg::OP_ADD_IP:  ip_sum_reg      <= acc_sum;
                udp_hdr_pkg::OP_EMIT: begin
                    if (do_emit) begin
                        emit_cnt_reg <= emit_cnt_reg + 5'd1;
                    end
                end
                udp_hdr_pkg::OP_CLEAR: begin
                    byte_count_reg  <= 16'd0;
                    running_sum_reg <= 17'd0;
                    held_high_reg   <= 8'd0;
                    odd_pending_reg <= 1'b0;
                    overflow_reg    <= 1'b0;
                    ip_sum_reg      <= 17'd0;
                    emit_cnt_reg    <= 5'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            m_byte_reg   <= hdr_byte;
            m_offset_reg <= emit_cnt_reg;
            m_last_reg   <= (emit_cnt_reg == udp_hdr_pkg::HDR_LAST);
            m_ovf_reg    <= overflow_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_header_byte     = m_byte_reg;
    assign m_header_offset   = m_offset_reg;
    assign m_header_last     = m_last_reg;
    assign m_length_overflow = m_ovf_reg;

endmodule

/* hdl/udp_ipv4_header_builder_core.sv */
`timescale 1ns / 1ps

// Builds the 28-byte IPv4 plus UDP header for a datagram whose payload arrives
// one byte per beat on the s_ channel, with s_last_byte marking the final byte.
// Payload beats are taken at one per cycle while the sequencer sits idle.
// After the last byte, a microprogram of 17 steps folds the pseudoheader and
// header words into the two checksums, then one emit step repeats for the 28
// header beats on the m_ channel, followed by one step that clears the
// datagram state. The next payload beat is taken only once the clear step
// has returned the sequencer to idle. A stalled receiver holds the emit
// step; the output register keeps its beat and nothing is lost. The
// registers on the cfg_ channel are to be written by the user only while
// the block is idle; the block itself does not enforce this. cfg_ready is
// always high and unknown indexes are ignored. Reset clears all datagram
// state and loads the register defaults.

module udp_ipv4_header_builder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_header_byte,
    output logic [4:0]  m_header_offset,
    output logic        m_header_last,
    output logic        m_length_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    udp_hdr_pkg::cfg_t    cfg_reg;
    udp_hdr_pkg::ctl_t    ctl;
    udp_hdr_pkg::status_t status;
    logic                 in_accept;
    logic                 emit_done;

    assign cfg_ready        = 1'b1;
    assign s_ready          = ctl.in_ready;
    assign in_accept        = s_valid && ctl.in_ready;
    assign status.start     = in_accept && s_last_byte;
    assign status.emit_done = emit_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_addr <= 32'hc0a80065;
            cfg_reg.src_port <= 16'hebd0;
            cfg_reg.dst_addr <= 32'd0;
            cfg_reg.dst_port <= 16'd0;
            cfg_reg.ttl      <= 8'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                udp_hdr_pkg::CFG_SRC_ADDR: cfg_reg.src_addr <= cfg_data;
                udp_hdr_pkg::CFG_SRC_PORT: cfg_reg.src_port <= cfg_data[15:0];
                udp_hdr_pkg::CFG_DST_ADDR: cfg_reg.dst_addr <= cfg_data;
                udp_hdr_pkg::CFG_DST_PORT: cfg_reg.dst_port <= cfg_data[15:0];
                udp_hdr_pkg::CFG_TTL:      cfg_reg.ttl      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    udp_hdr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctl     (ctl)
    );

    udp_hdr_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .ctl               (ctl),
        .in_accept         (in_accept),
        .in_byte           (s_payload_byte),
        .emit_done         (emit_done),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_header_byte     (m_header_byte),
        .m_header_offset   (m_header_offset),
        .m_header_last     (m_header_last),
        .m_length_overflow (m_length_overflow)
    );

endmodule
